/* src/vrtwc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrtwc_pkg
// Shared types, codes and constants of the telemetry word converter.
// ----------------------------------------------------------------------------
package vrtwc_pkg;

   localparam int MAX_PHASES    = 8;
   localparam int MID_DEPTH_DEF = 2;
   localparam int RSP_DEPTH_DEF = 2;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int VALUE_W     = 17;
   localparam int NUM_A_W     = 17;
   localparam int MAG_B_W     = 14;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = RECIP_SHIFT + 1;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_PROT_GAIN    = 3'd0;
   localparam logic [2:0] REG_VREF_MV      = 3'd1;
   localparam logic [2:0] REG_VOUT_MAX_MV  = 3'd2;
   localparam logic [2:0] REG_VOUT_OV_FIX  = 3'd3;
   localparam logic [2:0] REG_VOUT_IS_VID  = 3'd4;
   localparam logic [2:0] REG_VID_MODE     = 3'd5;
   localparam logic [2:0] REG_SENSE_GAIN   = 3'd6;
   localparam logic [2:0] REG_PHASE_COUNT  = 3'd7;

   // request types
   localparam logic [3:0] REQ_TEMP_LIMIT = 4'd0;
   localparam logic [3:0] REQ_VIN_OV     = 4'd1;
   localparam logic [3:0] REQ_VOUT_OV    = 4'd2;
   localparam logic [3:0] REQ_VOUT_UV    = 4'd3;
   localparam logic [3:0] REQ_VOUT       = 4'd4;
   localparam logic [3:0] REQ_POUT_PK    = 4'd5;
   localparam logic [3:0] REQ_IOUT_PK    = 4'd6;
   localparam logic [3:0] REQ_PHASE_CUR  = 4'd7;
   localparam logic [3:0] REQ_UNSUP      = 4'd8;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NODATA = 2'd1;
   localparam logic [1:0] ST_NOTSUP = 2'd2;

   // VID tables
   localparam logic [1:0] VID_VR12  = 2'd0;
   localparam logic [1:0] VID_VR13  = 2'd1;
   localparam logic [1:0] VID_IMVP9 = 2'd2;

   typedef struct packed {
      logic [4:0]  prot_gain;
      logic [13:0] vref_mv;
      logic [12:0] vout_max_mv;
      logic [14:0] vout_ov_fixed_mv;
      logic        vout_is_vid;
      logic [1:0]  vid_mode;
      logic [6:0]  sense_gain;
      logic [3:0]  phase_count;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      prot_gain:        5'd10,
      vref_mv:          14'd0,
      vout_max_mv:      13'd0,
      vout_ov_fixed_mv: 15'd0,
      vout_is_vid:      1'b0,
      vid_mode:         VID_VR13,
      sense_gain:       7'd50,
      phase_count:      4'd1
   };

   // classified transaction between front and back
   typedef struct packed {
      logic                 is_phase;
      logic [VALUE_W-1:0]   value;
      logic [1:0]           status;
      logic [NUM_A_W-1:0]   num_a;
      logic [RECIP_W-1:0]   recip_a;
      logic [MAG_B_W-1:0]   mag_b;
      logic                 neg_b;
      logic [RECIP_W-1:0]   recip_b;
   } mid_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [1:0]         status;
   } rsp_type;

endpackage
`default_nettype wire

/* src/vrtwc_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrtwc_fifo
// Small synchronous queue, register based.
// ----------------------------------------------------------------------------
module vrtwc_fifo #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* src/vrtwc_csr.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrtwc_csr
// APB configuration registers of the rail.
// ----------------------------------------------------------------------------
module vrtwc_csr import vrtwc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite && pready;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_PROT_GAIN:   cfg_in.prot_gain        = pwdata[4:0];
            REG_VREF_MV:     cfg_in.vref_mv          = pwdata[13:0];
            REG_VOUT_MAX_MV: cfg_in.vout_max_mv      = pwdata[12:0];
            REG_VOUT_OV_FIX: cfg_in.vout_ov_fixed_mv = pwdata[14:0];
            REG_VOUT_IS_VID: cfg_in.vout_is_vid      = pwdata[0];
            REG_VID_MODE:    cfg_in.vid_mode         = pwdata[1:0];
            REG_SENSE_GAIN:  cfg_in.sense_gain       = pwdata[6:0];
            REG_PHASE_COUNT: cfg_in.phase_count      = pwdata[3:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_PROT_GAIN:   prdata = CSR_DATA_W'(cfg_ff.prot_gain);
         REG_VREF_MV:     prdata = CSR_DATA_W'(cfg_ff.vref_mv);
         REG_VOUT_MAX_MV: prdata = CSR_DATA_W'(cfg_ff.vout_max_mv);
         REG_VOUT_OV_FIX: prdata = CSR_DATA_W'(cfg_ff.vout_ov_fixed_mv);
         REG_VOUT_IS_VID: prdata = CSR_DATA_W'(cfg_ff.vout_is_vid);
         REG_VID_MODE:    prdata = CSR_DATA_W'(cfg_ff.vid_mode);
         REG_SENSE_GAIN:  prdata = CSR_DATA_W'(cfg_ff.sense_gain);
         REG_PHASE_COUNT: prdata = CSR_DATA_W'(cfg_ff.phase_count);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

/* src/vrtwc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrtwc_front
// Request decode: finishes the simple conversions and prepares the
// reciprocal divides of the phase current request.
// ----------------------------------------------------------------------------
module vrtwc_front import vrtwc_pkg::*; (
   input  wire cfg_type     cfg,
   input  wire logic [3:0]  req_type,
   input  wire logic [15:0] req_raw_word,
   input  wire logic [3:0]  req_phase_index,
   input  wire logic [15:0] req_total_current_word,
   output mid_type          item
);

   // entry 0 holds the reciprocal of 1: a zero count or gain acts as one
   logic [RECIP_W-1:0] recip_np_tab [16];
   logic [RECIP_W-1:0] recip_g_tab  [128];

   for (genvar i = 0; i < 16; i++) begin : g_np_tab
      localparam int D = (i == 0) ? 1 : i;
      localparam logic [RECIP_W-1:0] R = RECIP_W'(((1 << RECIP_SHIFT) + D - 1) / D);
      assign recip_np_tab[i] = R;
   end

   for (genvar i = 0; i < 128; i++) begin : g_g_tab
      localparam int D = (i == 0) ? 1 : i;
      localparam logic [RECIP_W-1:0] R = RECIP_W'(((1 << RECIP_SHIFT) + D - 1) / D);
      assign recip_g_tab[i] = R;
   end

   logic [7:0]  lo_byte;
   logic [3:0]  step_k;
   logic [8:0]  vin_sum;
   logic [8:0]  fifty_k;
   logic [13:0] ov_track;
   logic [14:0] ov_min;
   logic [8:0]  k_scale;
   logic [10:0] uv_sub;
   logic [16:0] uv_val;
   logic [11:0] vid_code;
   logic [14:0] code_x5;
   logic [15:0] code_x10;
   logic [16:0] vout_val;
   logic        vid_bad;
   logic [13:0] pk_sum;
   logic [7:0]  cs_byte;
   logic [14:0] cs_x100;
   logic        cs_neg;
   logic [14:0] cs_diff;

   assign lo_byte  = req_raw_word[7:0];
   assign step_k   = {1'b0, req_raw_word[2:0]} + 4'd1;
   assign vin_sum  = {1'b0, lo_byte} + 9'd4;
   assign fifty_k  = 9'(step_k) * 9'd50;
   assign ov_track = 14'(cfg.vout_max_mv) + 14'(fifty_k);
   assign ov_min   = ({1'b0, ov_track} < cfg.vout_ov_fixed_mv) ?
                     {1'b0, ov_track} : cfg.vout_ov_fixed_mv;
   // (10*vref - 50*k*scale) is a multiple of ten, so the rounding is exact
   assign k_scale  = 9'(step_k) * 9'(cfg.prot_gain);
   assign uv_sub   = 11'(k_scale) * 11'd5;
   assign uv_val   = 17'(cfg.vref_mv) - 17'(uv_sub);
   assign vid_code = req_raw_word[11:0];
   assign code_x5  = 15'(vid_code) * 15'd5;
   assign code_x10 = 16'(vid_code) * 16'd10;
   assign pk_sum   = 14'(req_raw_word[12:0]) + 14'd2;
   assign cs_byte  = req_phase_index[0] ? req_raw_word[15:8] : req_raw_word[7:0];
   assign cs_x100  = 15'(cs_byte) * 15'd100;
   assign cs_neg   = (cs_x100 < 15'd9800);
   assign cs_diff  = cs_neg ? (15'd9800 - cs_x100) : (cs_x100 - 15'd9800);

   always_comb begin
      vid_bad  = 1'b0;
      vout_val = 17'(vid_code);
      if (cfg.vout_is_vid) begin
         if (vid_code == '0) begin
            vout_val = '0;
         end else begin
            unique case (cfg.vid_mode)
               VID_VR12:  vout_val = 17'(code_x5) + 17'd245;
               VID_VR13:  vout_val = 17'(code_x10) + 17'd490;
               VID_IMVP9: vout_val = 17'(code_x10) + 17'd190;
               default: begin
                  vout_val = '0;
                  vid_bad  = 1'b1;
               end
            endcase
         end
      end
   end

   always_comb begin
      item          = '0;
      item.status   = ST_OK;
      item.num_a    = 17'(req_total_current_word) + 17'(cfg.phase_count[3:1]);
      item.recip_a  = recip_np_tab[cfg.phase_count];
      item.mag_b    = 14'(cs_diff) + 14'(cfg.sense_gain[6:1]);
      item.neg_b    = cs_neg;
      item.recip_b  = recip_g_tab[cfg.sense_gain];
      unique case (req_type)
         REQ_TEMP_LIMIT: item.value = 17'(lo_byte);
         REQ_VIN_OV:     item.value = 17'(vin_sum[8:3]);
         REQ_VOUT_OV:    item.value = 17'(ov_min);
         REQ_VOUT_UV:    item.value = uv_val;
         REQ_VOUT: begin
            if (vid_bad) begin
               item.status = ST_NODATA;
            end else begin
               item.value = vout_val;
            end
         end
         REQ_POUT_PK, REQ_IOUT_PK: item.value = 17'(pk_sum[13:2]);
         REQ_PHASE_CUR: begin
            if (req_phase_index >= 4'(MAX_PHASES)) begin
               item.status = ST_NODATA;
            end else begin
               item.is_phase = 1'b1;
            end
         end
         REQ_UNSUP: item.status = ST_NOTSUP;
         default:   item.status = ST_NODATA;
      endcase
   end

endmodule
`default_nettype wire

/* src/vrtwc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrtwc_back
// Reciprocal multiply stage and phase current select.
// ----------------------------------------------------------------------------
module vrtwc_back import vrtwc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire mid_type mid_item,
   input  wire logic    mid_empty,
   output logic         mid_pop,
   output rsp_type      rsp_item,
   input  wire logic    rsp_full,
   output logic         rsp_push
);

   localparam int PROD_A_W = NUM_A_W + RECIP_W;
   localparam int PROD_B_W = MAG_B_W + RECIP_W;
   localparam int QB_W     = PROD_B_W - RECIP_SHIFT;

   logic                valid_ff, valid_in;
   logic                is_phase_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [1:0]          status_ff;
   logic [PROD_A_W-1:0] prod_a_ff;
   logic [PROD_B_W-1:0] prod_b_ff;
   logic                neg_b_ff;
   logic                advance;

   logic [VALUE_W-1:0]      q_a;
   logic [QB_W-1:0]         q_b;
   logic signed [VALUE_W:0] a_s, b_s, max_s;

   assign advance  = !valid_ff || !rsp_full;
   assign mid_pop  = advance && !mid_empty;
   assign valid_in = advance ? !mid_empty : valid_ff;
   assign rsp_push = valid_ff && !rsp_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_pop) begin
         is_phase_ff <= mid_item.is_phase;
         value_ff    <= mid_item.value;
         status_ff   <= mid_item.status;
         prod_a_ff   <= PROD_A_W'(mid_item.num_a) * PROD_A_W'(mid_item.recip_a);
         prod_b_ff   <= PROD_B_W'(mid_item.mag_b) * PROD_B_W'(mid_item.recip_b);
         neg_b_ff    <= mid_item.neg_b;
      end
   end

   assign q_a   = prod_a_ff[RECIP_SHIFT +: VALUE_W];
   assign q_b   = prod_b_ff[PROD_B_W-1:RECIP_SHIFT];
   assign a_s   = signed'({1'b0, q_a});
   assign b_s   = neg_b_ff ? -signed'((VALUE_W+1)'(q_b)) : signed'((VALUE_W+1)'(q_b));
   assign max_s = (a_s > b_s) ? a_s : b_s;

   always_comb begin
      rsp_item.status = status_ff;
      rsp_item.value  = is_phase_ff ? max_s[VALUE_W-1:0] : value_ff;
   end

endmodule
`default_nettype wire

/* src/vr_telemetry_word_converter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vr_telemetry_word_converter
// Converts raw regulator telemetry words of one rail to direct format.
//
//  channel  ports                          handshake
//  request  req_type/raw_word/phase_index/ push, full
//           total_current_word
//  result   rsp_value, rsp_status          pop, empty
//  config   paddr, pwdata, prdata          psel, penable, pwrite, pready
//
// One transaction per cycle sustained while the result queue has room; a
// result shows on the result ports once its request has passed the middle
// queue write, the multiply stage load and the result queue write. Reset
// empties both queues and loads the register reset values.
// A full result queue stalls the back end; the front keeps taking requests
// until the middle queue fills.
// ----------------------------------------------------------------------------
module vr_telemetry_word_converter import vrtwc_pkg::*; #(
   parameter int MID_DEPTH = MID_DEPTH_DEF,
   parameter int RSP_DEPTH = RSP_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire logic [3:0]            req_type,
   input  wire logic [15:0]           req_raw_word,
   input  wire logic [3:0]            req_phase_index,
   input  wire logic [15:0]           req_total_current_word,
   output logic                       empty,
   input  wire logic                  pop,
   output logic signed [VALUE_W-1:0]  rsp_value,
   output logic [1:0]                 rsp_status,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   cfg_type cfg;
   mid_type front_item, mid_item;
   rsp_type back_item, rsp_item;
   logic    mid_empty, mid_pop, mid_full;
   logic    rsp_push, rsp_full;

   vrtwc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   vrtwc_front u_front (
      .cfg                    (cfg),
      .req_type               (req_type),
      .req_raw_word           (req_raw_word),
      .req_phase_index        (req_phase_index),
      .req_total_current_word (req_total_current_word),
      .item                   (front_item)
   );

   vrtwc_fifo #(
      .DEPTH (MID_DEPTH),
      .WIDTH ($bits(mid_type))
   ) u_mid_q (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_item),
      .empty     (mid_empty)
   );

   assign full = mid_full;

   vrtwc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_item  (mid_item),
      .mid_empty (mid_empty),
      .mid_pop   (mid_pop),
      .rsp_item  (back_item),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push)
   );

   vrtwc_fifo #(
      .DEPTH (RSP_DEPTH),
      .WIDTH ($bits(rsp_type))
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_item),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_item),
      .empty     (empty)
   );

   assign rsp_value  = signed'(rsp_item.value);
   assign rsp_status = rsp_item.status;

endmodule
`default_nettype wire
